// ===== hdl/lbs_pkg.sv =====
// Shared types and constants for the largest-blob-by-color selector.
// Holds the classified record word that flows from the front part to the back part.
// No dependencies.
package lbs_pkg;

    localparam int MAX_BLOBS = 8;
    localparam int POS_W     = $clog2(MAX_BLOBS + 1);

    localparam int COORD_W = 8;
    localparam int AREA_W  = 16;
    localparam int IDX_W   = 3;
    localparam int COLOR_W = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA     = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic               empty;
        logic               last;
        logic               first;
        logic               in_range;
        logic               match;
        logic [IDX_W-1:0]   index;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_rec;

endpackage

// ===== hdl/lbs_front.sv =====
// Front part: takes blob records, tracks the position within the frame and
// classifies each record into a t_rec word for the queue. Depends on lbs_pkg.
module lbs_front
    import lbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COLOR_W-1:0] i_target_color,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COLOR_W-1:0] i_in_color,
    input  logic [COORD_W-1:0] i_in_x_left,
    input  logic [COORD_W-1:0] i_in_y_top,
    input  logic [COORD_W-1:0] i_in_x_right,
    input  logic [COORD_W-1:0] i_in_y_bottom,
    input  logic               i_in_last,
    input  logic               i_in_empty_frame,
    output logic               o_q_valid,
    input  logic               i_q_ready,
    output t_rec               o_q_data
);

    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic               accept;
    logic               in_range;
    logic [COORD_W:0]   sum_x;
    logic [COORD_W:0]   sum_y;

    assign o_in_ready = i_q_ready;
    assign o_q_valid  = i_in_valid;
    assign accept     = i_in_valid & i_q_ready;
    assign in_range   = (r_pos < POS_W'(MAX_BLOBS));

    always_comb begin
        sum_x = {1'b0, i_in_x_left} + {1'b0, i_in_x_right};
        sum_y = {1'b0, i_in_y_top} + {1'b0, i_in_y_bottom};

        o_q_data.empty    = i_in_empty_frame;
        o_q_data.last     = i_in_last;
        o_q_data.first    = (r_pos == '0);
        o_q_data.in_range = in_range;
        o_q_data.match    = (i_in_color == i_target_color);
        o_q_data.index    = IDX_W'(r_pos);
        o_q_data.center_x = sum_x[COORD_W:1];
        o_q_data.center_y = sum_y[COORD_W:1];
        o_q_data.width    = (i_in_x_left >= i_in_x_right) ? (i_in_x_left - i_in_x_right)
                                                          : (i_in_x_right - i_in_x_left);
        o_q_data.height   = (i_in_y_top >= i_in_y_bottom) ? (i_in_y_top - i_in_y_bottom)
                                                          : (i_in_y_bottom - i_in_y_top);
    end

    // The position saturates once MAX_BLOBS records are in; later records pass unscored.
    always_comb begin
        n_pos = r_pos;
        if (i_in_empty_frame || i_in_last) begin
            n_pos = '0;
        end else if (in_range) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== hdl/lbs_queue.sv =====
// Short queue of classified records between the front and back parts.
// Depends on lbs_pkg for t_rec and the depth constants.
module lbs_queue
    import lbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_rec i_wr_data,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_rec o_rd_data
);

    t_rec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_wr_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rptr];
    assign push       = i_wr_valid & o_wr_ready;
    assign pop        = o_rd_valid & i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

// ===== hdl/lbs_back.sv =====
// Back part: scores each queued record by area, keeps the running best and
// writes one result word per frame into the output register. Depends on lbs_pkg.
module lbs_back
    import lbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [AREA_W-1:0]  i_min_area,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  t_rec               i_q_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_out_found,
    output logic [IDX_W-1:0]   o_out_best_index,
    output logic [COORD_W-1:0] o_out_center_x,
    output logic [COORD_W-1:0] o_out_center_y,
    output logic [COORD_W-1:0] o_out_width,
    output logic [COORD_W-1:0] o_out_height,
    output logic [AREA_W-1:0]  o_out_area
);

    logic               r_have;
    logic [AREA_W-1:0]  r_best_area;
    logic [IDX_W-1:0]   r_idx;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic [COORD_W-1:0] r_w;
    logic [COORD_W-1:0] r_h;

    logic               r_o_valid;
    logic               r_o_found;
    logic [IDX_W-1:0]   r_o_idx;
    logic [COORD_W-1:0] r_o_cx;
    logic [COORD_W-1:0] r_o_cy;
    logic [COORD_W-1:0] r_o_w;
    logic [COORD_W-1:0] r_o_h;
    logic [AREA_W-1:0]  r_o_area;

    logic [AREA_W-1:0]  prod;
    logic [AREA_W-1:0]  base_area;
    logic               base_have;
    logic               take;
    logic               n_have;
    logic [AREA_W-1:0]  n_best_area;
    logic [IDX_W-1:0]   n_idx;
    logic [COORD_W-1:0] n_cx;
    logic [COORD_W-1:0] n_cy;
    logic [COORD_W-1:0] n_w;
    logic [COORD_W-1:0] n_h;
    logic               emit;
    logic               pop;

    // The first record of a frame starts from min_area with nothing chosen.
    always_comb begin
        prod        = {{(AREA_W-COORD_W){1'b0}}, i_q_data.width}
                    * {{(AREA_W-COORD_W){1'b0}}, i_q_data.height};
        base_area   = i_q_data.first ? i_min_area : r_best_area;
        base_have   = i_q_data.first ? 1'b0 : r_have;
        take        = !i_q_data.empty && i_q_data.in_range && i_q_data.match
                    && (prod >= base_area);
        n_have      = !i_q_data.empty && (take || base_have);
        n_best_area = take ? prod : base_area;
        n_idx       = take ? i_q_data.index    : r_idx;
        n_cx        = take ? i_q_data.center_x : r_cx;
        n_cy        = take ? i_q_data.center_y : r_cy;
        n_w         = take ? i_q_data.width    : r_w;
        n_h         = take ? i_q_data.height   : r_h;
        emit        = i_q_data.empty || i_q_data.last;
    end

    assign o_q_ready = !emit || !r_o_valid || i_out_ready;
    assign pop       = i_q_valid & o_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_have <= emit ? 1'b0 : n_have;
            end
            if (pop && emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_best_area <= n_best_area;
            r_idx       <= n_idx;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_w         <= n_w;
            r_h         <= n_h;
        end
        // A frame with nothing chosen reports zeros in every field.
        if (pop && emit) begin
            r_o_found <= n_have;
            r_o_idx   <= n_have ? n_idx : '0;
            r_o_cx    <= n_have ? n_cx : '0;
            r_o_cy    <= n_have ? n_cy : '0;
            r_o_w     <= n_have ? n_w : '0;
            r_o_h     <= n_have ? n_h : '0;
            r_o_area  <= n_have ? n_best_area : '0;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_out_found      = r_o_found;
    assign o_out_best_index = r_o_idx;
    assign o_out_center_x   = r_o_cx;
    assign o_out_center_y   = r_o_cy;
    assign o_out_width      = r_o_w;
    assign o_out_height     = r_o_h;
    assign o_out_area       = r_o_area;

endmodule

// ===== hdl/largest_blob_by_color_select.sv =====
// Largest blob by color selector, top level.
// Use: write target_color (index 0) and min_area (index 1) on the cfg channel
// while the block is idle; the cfg channel is always ready. Then stream a
// frame's blob records on the in channel, one word per record, with last on
// the final record, or a single word with empty_frame set for a frame with no
// records. One result word per frame leaves on the out channel: found, the
// index of the largest matching rectangle (later record wins a tie), its
// center, width, height and area; all fields are zero when nothing was found.
// Records past MAX_BLOBS in a frame are not scored.
// The last word of a frame passes through the queue before its result is
// registered. Throughput: one record per cycle while results are taken,
// set by the combinational area multiply and compare in the back part.
// A two-word queue separates the front and back parts, and the result sits in
// an output register, so records keep flowing while a result waits; when the
// receiver stalls, the back part holds at the next frame end and the queue
// then fills and drops in-channel ready.
// Reset (synchronous, active low) clears the configuration registers to zero,
// empties the queue and the output register and starts a new frame.
// Depends on lbs_pkg, lbs_front, lbs_queue and lbs_back.
module largest_blob_by_color_select
    import lbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COLOR_W-1:0]    i_in_color,
    input  logic [COORD_W-1:0]    i_in_x_left,
    input  logic [COORD_W-1:0]    i_in_y_top,
    input  logic [COORD_W-1:0]    i_in_x_right,
    input  logic [COORD_W-1:0]    i_in_y_bottom,
    input  logic                  i_in_last,
    input  logic                  i_in_empty_frame,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_out_found,
    output logic [IDX_W-1:0]      o_out_best_index,
    output logic [COORD_W-1:0]    o_out_center_x,
    output logic [COORD_W-1:0]    o_out_center_y,
    output logic [COORD_W-1:0]    o_out_width,
    output logic [COORD_W-1:0]    o_out_height,
    output logic [AREA_W-1:0]     o_out_area
);

    logic [COLOR_W-1:0] r_target_color;
    logic [AREA_W-1:0]  r_min_area;

    logic fq_valid;
    logic fq_ready;
    t_rec fq_data;
    logic qb_valid;
    logic qb_ready;
    t_rec qb_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_color <= '0;
            r_min_area     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TARGET_COLOR: r_target_color <= i_cfg_data[COLOR_W-1:0];
                CFG_MIN_AREA:     r_min_area     <= i_cfg_data[AREA_W-1:0];
                default:          r_min_area     <= r_min_area;
            endcase
        end
    end

    lbs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_target_color   (r_target_color),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_color       (i_in_color),
        .i_in_x_left      (i_in_x_left),
        .i_in_y_top       (i_in_y_top),
        .i_in_x_right     (i_in_x_right),
        .i_in_y_bottom    (i_in_y_bottom),
        .i_in_last        (i_in_last),
        .i_in_empty_frame (i_in_empty_frame),
        .o_q_valid        (fq_valid),
        .i_q_ready        (fq_ready),
        .o_q_data         (fq_data)
    );

    lbs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_data  (fq_data),
        .o_rd_valid (qb_valid),
        .i_rd_ready (qb_ready),
        .o_rd_data  (qb_data)
    );

    lbs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_min_area       (r_min_area),
        .i_q_valid        (qb_valid),
        .o_q_ready        (qb_ready),
        .i_q_data         (qb_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_found      (o_out_found),
        .o_out_best_index (o_out_best_index),
        .o_out_center_x   (o_out_center_x),
        .o_out_center_y   (o_out_center_y),
        .o_out_width      (o_out_width),
        .o_out_height     (o_out_height),
        .o_out_area       (o_out_area)
    );

endmodule

// ===== hdl/lbs_checker.sv =====
// Port-level checks for the largest blob by color selector, bound to the top level.
// Depends on lbs_pkg.
module lbs_checker
    import lbs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_out_found,
    input logic [IDX_W-1:0]   o_out_best_index,
    input logic [COORD_W-1:0] o_out_center_x,
    input logic [COORD_W-1:0] o_out_center_y,
    input logic [COORD_W-1:0] o_out_width,
    input logic [COORD_W-1:0] o_out_height,
    input logic [AREA_W-1:0]  o_out_area
);

    // A stalled result word keeps every field.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_found)
        && $stable(o_out_best_index) && $stable(o_out_center_x)
        && $stable(o_out_center_y) && $stable(o_out_width)
        && $stable(o_out_height) && $stable(o_out_area))
        else $error("result word changed while stalled");

    // A frame with nothing chosen reports all zeros.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_found |-> o_out_best_index == '0
        && o_out_center_x == '0 && o_out_center_y == '0 && o_out_width == '0
        && o_out_height == '0 && o_out_area == '0)
        else $error("not-found result carries nonzero fields");

    a_area_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_found |->
        o_out_area == AREA_W'(o_out_width) * AREA_W'(o_out_height))
        else $error("area is not width times height");

    // Center, width and height must describe corners that fit in the coordinate range.
    a_corners_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_found |->
        ({o_out_center_x, 1'b1} >= {1'b0, o_out_width})
        && ({1'b0, o_out_center_x, 1'b0} + {2'b0, o_out_width} <= 10'd510)
        && ({o_out_center_y, 1'b1} >= {1'b0, o_out_height})
        && ({1'b0, o_out_center_y, 1'b0} + {2'b0, o_out_height} <= 10'd510))
        else $error("center and size do not fit valid corners");

endmodule

bind largest_blob_by_color_select lbs_checker u_lbs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_found      (o_out_found),
    .o_out_best_index (o_out_best_index),
    .o_out_center_x   (o_out_center_x),
    .o_out_center_y   (o_out_center_y),
    .o_out_width      (o_out_width),
    .o_out_height     (o_out_height),
    .o_out_area       (o_out_area)
);
